// ===== rtl/assert_macros.svh =====
// Assertion macros used by the register file top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define MPR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define MPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mpr_pkg.sv =====
// Package with shared constants, types and helpers of the page register file.
package mpr_pkg;

  localparam int unsigned ENTRY_COUNT = 64;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned ENTRY_W     = 2 * WORD_W;
  localparam int unsigned BUS_ADDR_W  = 9;

  localparam logic [WORD_W-1:0] WMASK_RESET = 16'hFF0E;
  localparam logic [WORD_W-1:0] MARK_RESET  = 16'h0040;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_WRITABLE_MASK = 1'b0,
    CFG_MARK_MASK     = 1'b1
  } mpr_cfg_e;

  // Sequencer states, one-hot.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } mpr_state_e;

  // Access control toward the table.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mpr_ctl_t;

  // Entry number from the bus address: bits 4..1 low, clear bit 6 adds 16, bit 8 adds 32.
  function automatic logic [5:0] entry_of(input logic [BUS_ADDR_W-1:0] addr);
    logic [5:0] e;
    e = {addr[8], ~addr[6], addr[4:1]};
    return e;
  endfunction

endpackage

// ===== rtl/mpr_table.sv =====
// Synchronous entry store with one read and one write port and per-entry valid bits.
module mpr_table #(
  parameter int unsigned EntryCount = mpr_pkg::ENTRY_COUNT,
  parameter int unsigned IdxW       = $clog2(EntryCount)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mpr_pkg::mpr_ctl_t         ctl_i,
  input  logic [IdxW-1:0]           rd_idx_i,
  input  logic [IdxW-1:0]           wr_idx_i,
  input  logic [mpr_pkg::ENTRY_W-1:0] wr_data_i,
  output logic [mpr_pkg::ENTRY_W-1:0] rd_data_o,
  output logic                      rd_valid_o
);
  import mpr_pkg::*;

  logic [ENTRY_W-1:0]    mem [EntryCount];
  logic [EntryCount-1:0] valid_q;
  logic [ENTRY_W-1:0]    rd_data_q;
  logic                  rd_valid_q;

  // Storage array and registered read data.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_idx_i];
    end
  end

  // Valid bits: an entry not written since reset reads back with its valid bit clear.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_valid_q <= valid_q[rd_idx_i];
      end
    end
  end

  assign rd_data_o  = rd_data_q;
  assign rd_valid_o = rd_valid_q;

endmodule

// ===== rtl/mpr_merge.sv =====
// Read-modify-write logic that forms the new entry and the returned word.
module mpr_merge (
  input  logic [mpr_pkg::ENTRY_W-1:0] entry_i,
  input  logic                        entry_valid_i,
  input  logic                        mode_i,
  input  logic                        addr_half_i,
  input  logic                        high_lane_i,
  input  logic                        byte_access_i,
  input  logic [mpr_pkg::WORD_W-1:0]  write_data_i,
  input  logic [mpr_pkg::WORD_W-1:0]  writable_mask_i,
  input  logic [mpr_pkg::WORD_W-1:0]  mark_mask_i,
  output logic [mpr_pkg::ENTRY_W-1:0] new_entry_o,
  output logic [mpr_pkg::WORD_W-1:0]  result_o
);
  import mpr_pkg::*;

  logic [WORD_W-1:0] hi;
  logic [WORD_W-1:0] lo;
  logic [WORD_W-1:0] old_half;
  logic [WORD_W-1:0] data;
  logic [WORD_W-1:0] new_lo;

  // An entry that was never written holds zero.
  assign hi = entry_valid_i ? entry_i[ENTRY_W-1:WORD_W] : '0;
  assign lo = entry_valid_i ? entry_i[WORD_W-1:0] : '0;

  assign old_half = addr_half_i ? hi : lo;

  // Byte writes merge the low data byte into one lane of the chosen half.
  always_comb begin
    data = write_data_i;
    if (byte_access_i) begin
      if (high_lane_i) begin
        data = {write_data_i[7:0], old_half[7:0]};
      end else begin
        data = {old_half[15:8], write_data_i[7:0]};
      end
    end
  end

  // Descriptor write keeps only writable bits and clears the written mark.
  assign new_lo = (data & writable_mask_i) | (lo & ~(writable_mask_i | mark_mask_i));

  always_comb begin
    new_entry_o = {hi, lo};
    result_o    = old_half;
    if (mode_i) begin
      if (addr_half_i) begin
        new_entry_o = {data, lo & ~mark_mask_i};
        result_o    = data;
      end else begin
        new_entry_o = {hi, new_lo};
        result_o    = new_lo;
      end
    end
  end

endmodule

// ===== rtl/mmu_page_register_file.sv =====
// Top level of the bus-facing page address and descriptor register file.
//
//   Channel  Direction  Handshake                Word
//   in       input      in_valid_i / in_ready_o  mode, bus_address, byte_access, write_data
//   out      output     out_valid_o / out_ready_i read_data
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index, cfg_data
//
// For each word the table read issues at acceptance; the merge and write-back follow in
// ST_EXEC from the registered read data. A new word is accepted only in ST_IDLE, so
// not before the write-back of the previous word has taken place.
// If a result still waits in the output register, the write-back cycle stalls.
// Reset clears all entries at once through per-entry valid bits; no sweep is needed.
// Configuration writes are always accepted.
module mmu_page_register_file #(
  parameter int unsigned EntryCount = mpr_pkg::ENTRY_COUNT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           mode_i,
  input  logic [mpr_pkg::BUS_ADDR_W-1:0] bus_address_i,
  input  logic                           byte_access_i,
  input  logic [mpr_pkg::WORD_W-1:0]     write_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mpr_pkg::WORD_W-1:0]     read_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [mpr_pkg::WORD_W-1:0]     cfg_data_i
);
  import mpr_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned IdxW = $clog2(EntryCount);

  mpr_state_e        state_q, state_d;
  logic [WORD_W-1:0] wmask_q;
  logic [WORD_W-1:0] mark_q;
  logic [IdxW-1:0]   idx_q;
  logic              mode_q;
  logic              half_q;
  logic              lane_q;
  logic              byte_q;
  logic [WORD_W-1:0] data_q;
  logic              out_valid_q;
  logic [WORD_W-1:0] out_data_q;

  logic              in_fire;
  logic              exec_fire;
  logic [5:0]        entry_full;
  logic [IdxW-1:0]   entry_idx;
  mpr_ctl_t          tbl_ctl;
  logic [ENTRY_W-1:0] rd_entry;
  logic              rd_valid;
  logic [ENTRY_W-1:0] new_entry;
  logic [WORD_W-1:0] result;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign exec_fire   = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
  assign cfg_ready_o = 1'b1;

  assign entry_full = entry_of(bus_address_i);
  assign entry_idx  = entry_full[IdxW-1:0];

  // Read at acceptance, write back when the result is registered.
  assign tbl_ctl.rd_en = in_fire;
  assign tbl_ctl.wr_en = exec_fire && mode_q;

  mpr_table #(
    .EntryCount (EntryCount),
    .IdxW       (IdxW)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (tbl_ctl),
    .rd_idx_i   (entry_idx),
    .wr_idx_i   (idx_q),
    .wr_data_i  (new_entry),
    .rd_data_o  (rd_entry),
    .rd_valid_o (rd_valid)
  );

  mpr_merge u_merge (
    .entry_i         (rd_entry),
    .entry_valid_i   (rd_valid),
    .mode_i          (mode_q),
    .addr_half_i     (half_q),
    .high_lane_i     (lane_q),
    .byte_access_i   (byte_q),
    .write_data_i    (data_q),
    .writable_mask_i (wmask_q),
    .mark_mask_i     (mark_q),
    .new_entry_o     (new_entry),
    .result_o        (result)
  );

  // Sequencer: idle until a word arrives, then ST_EXEC until the write-back can take place.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state, configuration registers and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wmask_q     <= WMASK_RESET;
      mark_q      <= MARK_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (mpr_cfg_e'(cfg_index_i))
          CFG_WRITABLE_MASK: wmask_q <= cfg_data_i;
          CFG_MARK_MASK:     mark_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Held access word and output data.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      idx_q  <= entry_idx;
      mode_q <= mode_i;
      half_q <= bus_address_i[5];
      lane_q <= bus_address_i[0];
      byte_q <= byte_access_i;
      data_q <= write_data_i;
    end
    if (exec_fire) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;

  // Checks on the sequencing of table accesses.
  `MPR_ASSERT_NEXT(a_accept_to_exec, in_fire, state_q == ST_EXEC, "accept did not start write-back")
  `MPR_ASSERT_IMP(a_write_in_exec, tbl_ctl.wr_en, state_q == ST_EXEC, "table write outside write-back")
  `MPR_ASSERT_NEXT(a_exec_to_out, exec_fire, out_valid_o, "write-back produced no result")
  `MPR_ASSERT_IMP(a_no_read_in_exec, state_q == ST_EXEC, !tbl_ctl.rd_en, "table read during write-back")

endmodule
